// ===== hw/rtl/hrsc_pkg.sv =====
package hrsc_pkg;

  localparam int LenBitsDef = 31;
  localparam int OutLenW    = 31;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } hrsc_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         body_byte;
    logic [1:0]         method;
    logic [1:0]         status;
    logic [OutLenW-1:0] body_length;
    logic               last;
  } hrsc_out_t;

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BAD         = 2'd1;
  localparam logic [1:0] STAT_NOT_ALLOWED = 2'd2;

  localparam logic [1:0] HIT_NONE = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_BODY = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // token matcher: candidate mask, bytes seen, trim stage
  typedef struct packed {
    logic [2:0] alive;
    logic [3:0] len;
    logic [1:0] stage;
  } match_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [23:0] HDR_END_PREV = 24'h0D0A0D;

  // tokens left aligned in 16 characters
  localparam logic [127:0] TOK_GET    = {"GET", 104'h0};
  localparam logic [127:0] TOK_POST   = {"POST", 96'h0};
  localparam logic [127:0] TOK_DELETE = {"DELETE", 80'h0};
  localparam logic [127:0] TOK_VER    = {"HTTP/1.1", 64'h0};
  localparam logic [127:0] TOK_CLEN   = {"content-length", 16'h0};
  localparam logic [127:0] TOK_HOST   = {"host", 96'h0};
  localparam logic [127:0] TOK_CONN   = {"connection", 48'h0};
  localparam logic [127:0] TOK_KEEP   = {"keep-alive", 48'h0};
  localparam logic [127:0] TOK_CLOSE  = {"close", 88'h0};

  localparam logic [3:0] LEN_GET    = 4'd3;
  localparam logic [3:0] LEN_POST   = 4'd4;
  localparam logic [3:0] LEN_DELETE = 4'd6;
  localparam logic [3:0] LEN_VER    = 4'd8;
  localparam logic [3:0] LEN_CLEN   = 4'd14;
  localparam logic [3:0] LEN_HOST   = 4'd4;
  localparam logic [3:0] LEN_CONN   = 4'd10;
  localparam logic [3:0] LEN_KEEP   = 4'd10;
  localparam logic [3:0] LEN_CLOSE  = 4'd5;
  localparam logic [3:0] LEN_UNUSED = 4'd0;

  function automatic logic tok_ok(logic [127:0] s, logic [3:0] n, logic [3:0] p,
                                  logic [7:0] c);
    logic [127:0] sh;
    sh = s << {p, 3'b000};
    return (p < n) && (sh[127:120] == c);
  endfunction

  function automatic match_t m_init(logic [2:0] mask);
    match_t m;
    m.alive = mask;
    m.len   = 4'd0;
    m.stage = 2'd0;
    return m;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic match_t m_feed(match_t m, logic [7:0] c, logic trim,
                                    logic [2:0] ok);
    match_t n;
    n = m;
    if (trim && is_blank(c)) begin
      if (m.stage == 2'd1) n.stage = 2'd2;
    end else if (m.stage == 2'd2) begin
      n.alive = 3'b000;
    end else begin
      n.stage = 2'd1;
      n.alive = m.alive & ok;
      if (m.len != 4'hF) n.len = m.len + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [1:0] m_hit(match_t m, logic [3:0] l0, logic [3:0] l1,
                                       logic [3:0] l2);
    logic [1:0] r;
    r = HIT_NONE;
    if (m.alive[2] && m.len == l2) r = 2'd2;
    if (m.alive[1] && m.len == l1) r = 2'd1;
    if (m.alive[0] && m.len == l0) r = 2'd0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hrsc_oq.sv =====
module hrsc_oq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hrsc_pkg::hrsc_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output hrsc_pkg::hrsc_out_t out_data
);
  import hrsc_pkg::*;

  hrsc_out_t  q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q0_nxt = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
    if (push) begin
      cnt_nxt = cnt_nxt + 2'd1;
      if (cnt_nxt == 2'd1) q0_nxt = push_data;
      else q1_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/http_request_stream_checker.sv =====
// a result is registered in the result queue and appears at out_data once any entries ahead of it are taken
// throughput: one input transaction per cycle while in_stall is low; the per-byte parser update is a single
//   combinational pass between the state registers and a two-entry result queue
// input stalls only while both result queue entries are occupied
// reset (rst_n low, synchronous) returns the parser to the request line and empties the queue
module http_request_stream_checker #(
  parameter int LENGTH_BITS = hrsc_pkg::LenBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrsc_pkg::hrsc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrsc_pkg::hrsc_out_t out_data
);
  import hrsc_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LenMax = {LB{1'b1}};

  // whole parser context
  typedef struct packed {
    phase_t        phase;
    logic [23:0]   recent;
    logic          cr;        // carriage return held back
    logic [1:0]    line;      // 0 request line, 1 first header, 2 later
    logic [1:0]    spc;       // spaces on request line, saturating
    match_t        meth;
    match_t        ver;
    logic [1:0]    path;      // 0 empty, 1 slash, 2 bad
    match_t        name;
    logic          colon;
    match_t        val;
    logic          nonblank;
    logic [LB-1:0] acc;
    logic [2:0]    lflags;    // [2] negative, [1:0] scan stage
    logic          host;
    logic [2:0]    err;       // [0] 400 request line, [1] 405, [2] header line
    logic [LB-1:0] rem;
    logic [1:0]    mcode;
  } st_t;

  st_t       st_r, st_nxt;
  logic      accept;
  logic      res_v;
  hrsc_out_t res;
  logic      q_full;

  function automatic st_t line_init(st_t s);
    st_t n;
    n          = s;
    n.name     = m_init(3'b111);
    n.colon    = 1'b0;
    n.val      = m_init(3'b011);
    n.nonblank = 1'b0;
    n.acc      = '0;
    n.lflags   = 3'd0;
    return n;
  endfunction

  function automatic st_t reset_st();
    st_t n;
    n.phase    = PH_HDR;
    n.recent   = 24'd0;
    n.cr       = 1'b0;
    n.line     = 2'd0;
    n.spc      = 2'd0;
    n.meth     = m_init(3'b111);
    n.ver      = m_init(3'b001);
    n.path     = 2'd0;
    n.name     = m_init(3'b111);
    n.colon    = 1'b0;
    n.val      = m_init(3'b011);
    n.nonblank = 1'b0;
    n.acc      = '0;
    n.lflags   = 3'd0;
    n.host     = 1'b0;
    n.err      = 3'd0;
    n.rem      = '0;
    n.mcode    = 2'd0;
    return n;
  endfunction

  // strtoll style scan of a content-length value, one byte
  function automatic st_t len_feed(st_t s, logic [7:0] c);
    st_t           n;
    logic [LB+3:0] prod;
    logic          ws;
    n    = s;
    ws   = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
    prod = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {{LB{1'b0}}, c[3:0]};
    if (s.lflags[1:0] != 2'd3) begin
      if (s.lflags[1:0] == 2'd0 && ws) begin
        n.lflags = s.lflags;
      end else if (s.lflags[1:0] == 2'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
        n.lflags = {c == CH_MINUS, 2'b01};
      end else if (c >= CH_0 && c <= CH_9) begin
        if (prod > {4'd0, LenMax}) n.acc = LenMax;
        else n.acc = prod[LB-1:0];
        n.lflags = {s.lflags[2], 2'b10};
      end else begin
        n.lflags = {s.lflags[2], 2'b11};
      end
    end
    return n;
  endfunction

  // one ordinary character of the current line
  function automatic st_t content(st_t s, logic [7:0] c);
    st_t        n;
    logic [7:0] lc;
    logic [2:0] ok;
    n  = s;
    lc = c;
    ok = 3'b000;
    if (s.line == 2'd0) begin
      if (c == CH_SP) begin
        if (s.spc != 2'd3) n.spc = s.spc + 2'd1;
      end else if (s.spc == 2'd0) begin
        ok = {tok_ok(TOK_DELETE, LEN_DELETE, s.meth.len, c),
              tok_ok(TOK_POST, LEN_POST, s.meth.len, c),
              tok_ok(TOK_GET, LEN_GET, s.meth.len, c)};
        n.meth = m_feed(s.meth, c, 1'b0, ok);
      end else if (s.spc == 2'd1) begin
        if (s.path == 2'd0) n.path = (c == CH_SLASH) ? 2'd1 : 2'd2;
      end else if (s.spc == 2'd2) begin
        ok = {2'b00, tok_ok(TOK_VER, LEN_VER, s.ver.len, c)};
        n.ver = m_feed(s.ver, c, 1'b0, ok);
      end
    end else if (!s.colon) begin
      if (c == CH_COLON) begin
        n.colon = 1'b1;
      end else begin
        if (c >= CH_UA && c <= CH_UZ) lc = c + 8'd32;
        ok = {tok_ok(TOK_CONN, LEN_CONN, s.name.len, lc),
              tok_ok(TOK_HOST, LEN_HOST, s.name.len, lc),
              tok_ok(TOK_CLEN, LEN_CLEN, s.name.len, lc)};
        n.name = m_feed(s.name, lc, 1'b1, ok);
      end
    end else begin
      if (!is_blank(c)) n.nonblank = 1'b1;
      ok = {1'b0, tok_ok(TOK_CLOSE, LEN_CLOSE, s.val.len, c),
            tok_ok(TOK_KEEP, LEN_KEEP, s.val.len, c)};
      n.val = m_feed(s.val, c, 1'b1, ok);
      n = len_feed(n, c);
    end
    return n;
  endfunction

  // line closed by crlf
  function automatic st_t end_line(st_t s);
    st_t        n;
    logic [1:0] mi;
    logic [1:0] ni;
    n  = s;
    mi = m_hit(s.meth, LEN_GET, LEN_POST, LEN_DELETE);
    ni = m_hit(s.name, LEN_CLEN, LEN_HOST, LEN_CONN);
    if (s.line == 2'd0) begin
      if (s.spc != 2'd2) begin
        n.err[0] = 1'b1;
      end else if (mi == HIT_NONE) begin
        n.err[1] = 1'b1;
      end else begin
        n.mcode = mi;
        if (m_hit(s.ver, LEN_VER, LEN_UNUSED, LEN_UNUSED) != 2'd0 || s.path != 2'd1)
          n.err[0] = 1'b1;
      end
    end else if (!s.colon) begin
      n.err[2] = 1'b1;
    end else if (ni == 2'd0) begin
      n.rem = s.lflags[2] ? '0 : s.acc;
    end else if (ni == 2'd1) begin
      if (s.nonblank) n.host = 1'b1;
      else n.err[2] = 1'b1;
    end else if (ni == 2'd2) begin
      if (m_hit(s.val, LEN_KEEP, LEN_CLOSE, LEN_UNUSED) == HIT_NONE) n.err[2] = 1'b1;
    end
    n = line_init(n);
    if (s.line != 2'd2) n.line = s.line + 2'd1;
    return n;
  endfunction

  function automatic logic [OutLenW-1:0] len_out(logic [LB-1:0] v);
    logic [LB+OutLenW-1:0] w;
    w = {{OutLenW{1'b0}}, v};
    return w[OutLenW-1:0];
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  always_comb begin
    st_t        s1;
    st_t        s2;
    logic [7:0] b;
    logic [1:0] stat;
    logic [LB-1:0] rem_d;
    st_nxt = st_r;
    res_v  = 1'b0;
    res    = '0;
    b      = in_data.data;
    s1     = st_r;
    s2     = st_r;
    stat   = STAT_OK;
    rem_d  = st_r.rem - {{(LB-1){1'b0}}, 1'b1};
    if (accept) begin
      if (in_data.op) begin
        // restart: fresh request, no result
        st_nxt = reset_st();
      end else if (st_r.phase == PH_BODY) begin
        // body byte pass-through
        res_v         = 1'b1;
        res.kind      = KIND_BODY;
        res.body_byte = b;
        st_nxt.rem    = rem_d;
        if (rem_d == '0) begin
          res.last     = 1'b1;
          st_nxt.phase = PH_DONE;
        end
      end else if (st_r.phase == PH_HDR) begin
        s1        = st_r;
        s1.recent = {st_r.recent[15:0], b};
        s1.cr     = 1'b0;
        if (st_r.cr && b == CH_LF) begin
          if (st_r.recent == HDR_END_PREV) begin
            // end of header: pick status by error priority
            priority if (s1.line != 2'd2 || s1.err[0]) stat = STAT_BAD;
            else if (s1.err[1]) stat = STAT_NOT_ALLOWED;
            else if (s1.err[2] || !s1.host) stat = STAT_BAD;
            else stat = STAT_OK;
            res_v  = 1'b1;
            st_nxt = s1;
            if (stat != STAT_OK) begin
              res.kind     = KIND_REJECT;
              res.status   = stat;
              res.last     = 1'b1;
              st_nxt.phase = PH_DONE;
            end else begin
              res.kind        = KIND_ACCEPT;
              res.method      = s1.mcode;
              res.body_length = len_out(s1.rem);
              res.last        = (s1.rem == '0);
              st_nxt.phase    = (s1.rem == '0) ? PH_DONE : PH_BODY;
            end
          end else begin
            st_nxt = end_line(s1);
          end
        end else begin
          // a held carriage return not followed by lf is plain content
          s2 = st_r.cr ? content(s1, CH_CR) : s1;
          if (b == CH_CR) s2.cr = 1'b1;
          else s2 = content(s2, b);
          st_nxt = s2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= reset_st();
    end else begin
      st_r <= st_nxt;
    end
  end

  // result queue decouples the stall of the result side
  hrsc_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_v),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
